FILE: hw/rtl/htcc_pkg.sv
package htcc_pkg;

    localparam int MAX_TRACKS  = 64;
    localparam int NUM_PADDLES = 16;

    localparam int IDX_W     = $clog2(MAX_TRACKS);
    localparam int CNT_W     = $clog2(MAX_TRACKS + 1);
    localparam int OUT_IDX_W = 6;
    localparam int PAD_W     = 4;
    localparam int TIME_W    = 16;
    localparam int HITS_W    = 8;
    localparam int MASK_W    = NUM_PADDLES + 1;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [OUT_IDX_W-1:0] t_out_idx;
    typedef logic [PAD_W-1:0]     t_pad;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [HITS_W-1:0]    t_hits;
    typedef logic [MASK_W-1:0]    t_mask;

    localparam t_cnt  CNT_FULL     = t_cnt'(MAX_TRACKS);
    localparam t_hits COUNT_MAX    = t_hits'(255);
    localparam t_time WINDOW_RESET = t_time'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_NEW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic event_start;
        logic punch_through;
        t_pad paddle;
        t_time hit_time;
    } t_hit;

    typedef struct packed {
        t_time seed;
        t_mask mask;
        t_hits hits;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_out_idx track_index;
        logic     new_track;
        logic     duplicate_paddle;
        t_hits    track_hits;
        logic     table_overflow;
    } t_result;

    // Bit 0 marks the punch-through counter, bit p+1 marks paddle p.
    function automatic t_mask mask_bit(input logic pt, input t_pad pad);
        logic [PAD_W:0] sh;
        sh = {1'b0, pad} + {{PAD_W{1'b0}}, 1'b1};
        if (pt) begin
            return t_mask'(1);
        end
        return t_mask'(1) << sh;
    endfunction

endpackage

FILE: hw/rtl/htcc_hit_if.sv
interface htcc_hit_if;
    logic                valid;
    logic                ready;
    logic                event_start;
    logic                punch_through;
    htcc_pkg::t_pad      paddle;
    htcc_pkg::t_time     hit_time;

    modport source (output valid, output event_start, output punch_through,
                    output paddle, output hit_time, input ready);
    modport sink   (input valid, input event_start, input punch_through,
                    input paddle, input hit_time, output ready);
endinterface

FILE: hw/rtl/htcc_res_if.sv
interface htcc_res_if;
    logic                valid;
    logic                ready;
    htcc_pkg::t_out_idx  track_index;
    logic                new_track;
    logic                duplicate_paddle;
    htcc_pkg::t_hits     track_hits;
    logic                table_overflow;

    modport source (output valid, output track_index, output new_track,
                    output duplicate_paddle, output track_hits,
                    output table_overflow, input ready);
    modport sink   (input valid, input track_index, input new_track,
                    input duplicate_paddle, input track_hits,
                    input table_overflow, output ready);
endinterface

FILE: hw/rtl/htcc_cfg_if.sv
interface htcc_cfg_if;
    logic            valid;
    logic            ready;
    htcc_pkg::t_time coincidence_window;

    modport source (output valid, output coincidence_window, input ready);
    modport sink   (input valid, input coincidence_window, output ready);
endinterface

FILE: hw/rtl/htcc_ram.sv
module htcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/htcc_cmp.sv
module htcc_cmp (
    input  htcc_pkg::t_time i_hit_time,
    input  htcc_pkg::t_time i_seed_time,
    input  htcc_pkg::t_time i_window,
    output logic            o_match
);

    htcc_pkg::t_time diff;

    always_comb begin
        if (i_hit_time >= i_seed_time) begin
            diff = i_hit_time - i_seed_time;
        end else begin
            diff = i_seed_time - i_hit_time;
        end
        o_match = (diff < i_window);
    end

endmodule

FILE: hw/rtl/hit_time_coincidence_clusterer.sv
// Time-coincidence hit clusterer for one detector event at a time.
// Hits enter on i_hit; each accepted transaction yields exactly one result
// transaction on o_res. i_cfg writes the coincidence window and is always
// ready; write it only while no hit is in flight.
// A hit with event_start set empties the track table before it is handled.
// The block holds i_hit.ready low while one hit is processed. A single
// comparator walks the stored track seeds, one per cycle, through a RAM
// with a registered read port, so the track count sets the latency. States in order:
//   punch-through hit:                 IDLE, NEW, DONE
//   hit that joins track k:            IDLE, SCAN of tracks 0 to k, UPD, DONE
//   hit that seeds a track (n stored): IDLE, SCAN of all n, NEW, DONE (also when full)
// The block is ready again in the cycle the result is registered.
// The result sits in an output register. If the receiver stalls, the next
// hit is still accepted and processed, and it waits for the output register
// to free before finishing.
// After reset the table is empty and the window is 3; no clearing pass runs,
// since only table entries that were written are ever read.
module hit_time_coincidence_clusterer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htcc_hit_if.sink   i_hit,
    htcc_res_if.source o_res,
    htcc_cfg_if.sink   i_cfg
);

    htcc_pkg::t_state  r_state, n_state;
    htcc_pkg::t_hit    r_hit, n_hit;
    htcc_pkg::t_cnt    r_count, n_count;
    htcc_pkg::t_cnt    r_idx, n_idx;
    logic              r_pend, n_pend;
    htcc_pkg::t_idx    r_pend_idx, n_pend_idx;
    htcc_pkg::t_result r_rslt, n_rslt;
    logic              r_out_valid, n_out_valid;
    htcc_pkg::t_result r_out, n_out;
    htcc_pkg::t_time   r_window, n_window;

    logic              wr_en;
    htcc_pkg::t_idx    wr_addr;
    htcc_pkg::t_entry  wr_data;
    logic              rd_en;
    htcc_pkg::t_entry  rd_data;
    logic              match;
    htcc_pkg::t_mask   hit_bit;
    htcc_pkg::t_hits   sat_hits;

    htcc_ram #(
        .WIDTH (htcc_pkg::ENTRY_W),
        .DEPTH (htcc_pkg::MAX_TRACKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[htcc_pkg::IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    htcc_cmp u_cmp (
        .i_hit_time  (r_hit.hit_time),
        .i_seed_time (rd_data.seed),
        .i_window    (r_window),
        .o_match     (match)
    );

    assign i_hit.ready = (r_state == htcc_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid            = r_out_valid;
    assign o_res.track_index      = r_out.track_index;
    assign o_res.new_track        = r_out.new_track;
    assign o_res.duplicate_paddle = r_out.duplicate_paddle;
    assign o_res.track_hits       = r_out.track_hits;
    assign o_res.table_overflow   = r_out.table_overflow;

    assign hit_bit  = htcc_pkg::mask_bit(r_hit.punch_through, r_hit.paddle);
    assign sat_hits = (rd_data.hits == htcc_pkg::COUNT_MAX) ? rd_data.hits
                                                             : rd_data.hits + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_hit       = r_hit;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_rslt      = r_rslt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_window    = r_window;
        wr_en       = 1'b0;
        wr_addr     = r_pend_idx;
        wr_data     = rd_data;
        rd_en       = 1'b0;

        if (i_cfg.valid) begin
            n_window = i_cfg.coincidence_window;
        end
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            htcc_pkg::ST_IDLE: begin
                if (i_hit.valid) begin
                    n_hit.event_start   = i_hit.event_start;
                    n_hit.punch_through = i_hit.punch_through;
                    n_hit.paddle        = i_hit.paddle;
                    n_hit.hit_time      = i_hit.hit_time;
                    if (i_hit.event_start) begin
                        n_count = '0;
                    end
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_state = i_hit.punch_through ? htcc_pkg::ST_NEW
                                                  : htcc_pkg::ST_SCAN;
                end
            end
            htcc_pkg::ST_SCAN: begin
                if (r_pend && match) begin
                    n_state = htcc_pkg::ST_UPD;
                end else if (r_idx >= r_count) begin
                    n_state = htcc_pkg::ST_NEW;
                end else begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[htcc_pkg::IDX_W-1:0];
                    n_idx      = r_idx + 1'b1;
                end
            end
            htcc_pkg::ST_UPD: begin
                wr_en        = 1'b1;
                wr_addr      = r_pend_idx;
                wr_data.seed = rd_data.seed;
                wr_data.mask = rd_data.mask | hit_bit;
                wr_data.hits = sat_hits;
                n_rslt.track_index      = htcc_pkg::t_out_idx'(r_pend_idx);
                n_rslt.new_track        = 1'b0;
                n_rslt.duplicate_paddle = |(rd_data.mask & hit_bit);
                n_rslt.track_hits       = sat_hits;
                n_rslt.table_overflow   = 1'b0;
                n_state = htcc_pkg::ST_DONE;
            end
            htcc_pkg::ST_NEW: begin
                if (r_count == htcc_pkg::CNT_FULL) begin
                    n_rslt = '0;
                    n_rslt.table_overflow = 1'b1;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = r_count[htcc_pkg::IDX_W-1:0];
                    wr_data.seed = r_hit.hit_time;
                    wr_data.mask = hit_bit;
                    wr_data.hits = htcc_pkg::t_hits'(1);
                    n_count      = r_count + 1'b1;
                    n_rslt.track_index      = htcc_pkg::t_out_idx'(r_count);
                    n_rslt.new_track        = 1'b1;
                    n_rslt.duplicate_paddle = 1'b0;
                    n_rslt.track_hits       = htcc_pkg::t_hits'(1);
                    n_rslt.table_overflow   = 1'b0;
                end
                n_state = htcc_pkg::ST_DONE;
            end
            htcc_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_rslt;
                    n_state     = htcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = htcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htcc_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= htcc_pkg::WINDOW_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_window    <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_pend_idx <= n_pend_idx;
        r_rslt     <= n_rslt;
        r_out      <= n_out;
    end

endmodule
